// ===== src/alvc_pkg.sv =====
// Shared types, constants and calibration tables for the ADC voltage calibration block.
// No dependencies; imported by every module of the block.
`default_nettype none

package alvc_pkg;

    localparam int CODE_W    = 12;
    localparam int VOLT_W    = 12;
    localparam int FUSE_W    = 5;
    localparam int TDATA_W   = 16;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 3;
    localparam int IDX_W     = 5;
    localparam int FRAC_W    = 7;
    localparam int K_W       = 16;
    localparam int XD_W      = 8;
    localparam int NPTS      = 20;
    localparam int TAB_W     = 12;

    localparam int ALVC_QUEUE_DEPTH = 4;

    // Register index of the fuse code (byte address 4*i)
    localparam logic [ADDR_W-3:0] REG_FUSE = '0;

    // Region of an input code
    localparam logic [1:0] REGION_ZERO  = 2'd0;
    localparam logic [1:0] REGION_LIN   = 2'd1;
    localparam logic [1:0] REGION_BLEND = 2'd2;
    localparam logic [1:0] REGION_TAB   = 2'd3;

    localparam int LO_THRESH  = 2880;
    localparam int STEP       = 64;
    localparam int BLEND_HI   = LO_THRESH + STEP;
    localparam int VREF_MID   = 1100;
    localparam int VREF_STEP  = 7;
    localparam int VREF_LO    = 1000;
    localparam int VREF_HI    = 1200;
    localparam int LIN_SCALE  = 196602;
    localparam int LIN_RND    = 32768;
    localparam int LIN_OFFSET = 142;
    localparam int VOLT_MAX   = 4095;

    // Table divisor (VREF_HI-VREF_LO)*STEP = 12800 = 25 * 2^9
    localparam int TAB_DIV    = (VREF_HI - VREF_LO) * STEP;
    localparam int TAB_RND    = TAB_DIV / 2;
    localparam int PRE_SHIFT  = 9;
    localparam int DIV_K      = TAB_DIV / (1 << PRE_SHIFT);
    localparam int DIV_SHIFT  = 20;
    localparam int DIV_MUL    = (1 << DIV_SHIFT) / DIV_K;

    localparam logic [TAB_W-1:0] TAB_LOW [NPTS] = '{
        12'd2240, 12'd2297, 12'd2352, 12'd2405, 12'd2457,
        12'd2512, 12'd2564, 12'd2616, 12'd2664, 12'd2709,
        12'd2754, 12'd2795, 12'd2832, 12'd2868, 12'd2903,
        12'd2937, 12'd2969, 12'd3000, 12'd3030, 12'd3060};

    localparam logic [TAB_W-1:0] TAB_HIGH [NPTS] = '{
        12'd2667, 12'd2706, 12'd2745, 12'd2780, 12'd2813,
        12'd2844, 12'd2873, 12'd2901, 12'd2928, 12'd2956,
        12'd2982, 12'd3006, 12'd3032, 12'd3059, 12'd3084,
        12'd3110, 12'd3135, 12'd3160, 12'd3184, 12'd3209};

    // Classified input item handed from the front to the back
    typedef struct packed {
        logic [1:0]        region;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] y1d;
        logic [FRAC_W-1:0] y2d;
        logic [FRAC_W-1:0] x;
    } alvc_item_t;

    // Values derived from the fuse code; one of the two weights goes negative when the
    // reference lies outside 1000..1200 mV (x1d below 1000 mV, x2d above 1200 mV)
    typedef struct packed {
        logic [K_W-1:0]         k;
        logic signed [XD_W:0]   x2d;
        logic signed [XD_W:0]   x1d;
    } alvc_cfg_t;

endpackage

`default_nettype wire

// ===== src/alvc_front.sv =====
// Front part: classifies an incoming ADC code into its region and table position.
// Depends on alvc_pkg.
`default_nettype none

module alvc_front import alvc_pkg::*; (
    input  wire logic [CODE_W-1:0] code,
    output alvc_item_t             item
);

    logic [CODE_W-1:0] off;

    assign off = code - CODE_W'(LO_THRESH);

    always_comb begin
        item.code   = code;
        item.region = REGION_ZERO;
        item.idx    = '0;
        item.y1d    = '0;
        item.y2d    = '0;
        item.x      = '0;
        if (code == '0) begin
            item.region = REGION_ZERO;
        end else if (code < CODE_W'(LO_THRESH)) begin
            item.region = REGION_LIN;
        end else begin
            // off tops out at 1215, so the index never passes the last segment
            item.idx = off[IDX_W+5:6];
            item.y1d = {1'b0, off[5:0]};
            item.y2d = FRAC_W'(STEP) - {1'b0, off[5:0]};
            if (code inside {[LO_THRESH:BLEND_HI]}) begin
                item.region = REGION_BLEND;
                item.x      = off[FRAC_W-1:0];
            end else begin
                item.region = REGION_TAB;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/alvc_queue.sv =====
// Short register queue between the front and the back of the calibration block.
// Depends on alvc_pkg.
`default_nettype none

module alvc_queue import alvc_pkg::*; #(
    parameter int DEPTH = ALVC_QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire alvc_item_t push_item,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output alvc_item_t      pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    alvc_item_t     slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/alvc_back.sv =====
// Back part: six-stage arithmetic pipeline (linear formula, bilinear table, blend).
// Depends on alvc_pkg; fed from alvc_queue.
`default_nettype none

module alvc_back import alvc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire alvc_cfg_t          cfg,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire alvc_item_t         q_item,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata     // [11:0] voltage_mv, upper bits zero
);

    function automatic logic signed [21:0] tab_mul(input logic [TAB_W-1:0] t,
                                                   input logic signed [XD_W:0] w);
        logic signed [21:0] a;
        logic signed [21:0] b;
        begin
            a = 22'($signed({1'b0, t}));
            b = 22'(w);
            return a * b;
        end
    endfunction

    logic                   adv;
    logic [IDX_W-1:0]       idx1;
    logic signed [XD_W:0]   x2d_s;

    // stage 1: table products and linear product
    logic                   st1_valid_reg;
    alvc_item_t             st1_item_reg;
    logic signed [21:0]     p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [21:0]     p0_next, p1_next, p2_next, p3_next;
    logic [27:0]            lp_reg, lp_next;

    // stage 2: reference interpolation and linear rounding
    logic                   st2_valid_reg;
    alvc_item_t             st2_item_reg;
    logic signed [22:0]     a_reg, b_reg, a_next, b_next;
    logic [VOLT_W-1:0]      lin2_reg, lin2_next;
    logic [28:0]            lin_rnd;

    // stage 3: code interpolation, pre-shift of the divisor
    logic                   st3_valid_reg;
    alvc_item_t             st3_item_reg;
    logic signed [31:0]     s_sum;
    logic [16:0]            t3_reg, t3_next;
    logic [VOLT_W-1:0]      lin3_reg;

    // stage 4: reciprocal multiply
    logic                   st4_valid_reg;
    alvc_item_t             st4_item_reg;
    logic [32:0]            qm;
    logic [12:0]            q0_reg, q0_next;
    logic [16:0]            t4_reg;
    logic [VOLT_W-1:0]      lin4_reg;

    // stage 5: quotient correction
    logic                   st5_valid_reg;
    alvc_item_t             st5_item_reg;
    logic [16:0]            rem;
    logic [12:0]            lut_reg, lut_next;
    logic [VOLT_W-1:0]      lin5_reg;

    // stage 6: region select, blend, output register
    logic                   m_tvalid_reg;
    logic [VOLT_W-1:0]      m_volt_reg, m_volt_next;
    logic [19:0]            blend_sum;
    logic [13:0]            val;

    assign adv      = !m_tvalid_reg || m_tready;
    assign q_pop    = adv && q_valid;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_volt_reg);

    assign idx1  = q_item.idx + IDX_W'(1);
    assign x2d_s = cfg.x2d;

    always_comb begin
        p0_next = tab_mul(TAB_LOW[q_item.idx], x2d_s);
        p1_next = tab_mul(TAB_HIGH[q_item.idx], cfg.x1d);
        p2_next = tab_mul(TAB_LOW[idx1], x2d_s);
        p3_next = tab_mul(TAB_HIGH[idx1], cfg.x1d);
        lp_next = 28'(cfg.k) * 28'(q_item.code);
    end

    always_comb begin
        a_next    = 23'(p0_reg) + 23'(p1_reg);
        b_next    = 23'(p2_reg) + 23'(p3_reg);
        lin_rnd   = 29'(lp_reg) + 29'(LIN_RND);
        lin2_next = VOLT_W'(lin_rnd[28:16]) + VOLT_W'(LIN_OFFSET);
    end

    always_comb begin
        s_sum = 32'(a_reg) * 32'($signed({1'b0, st2_item_reg.y2d}))
              + 32'(b_reg) * 32'($signed({1'b0, st2_item_reg.y1d}))
              + 32'(TAB_RND);
        t3_next = s_sum[PRE_SHIFT+16:PRE_SHIFT];
    end

    always_comb begin
        qm      = 33'(t3_reg) * 33'(DIV_MUL);
        q0_next = qm[32:DIV_SHIFT];
    end

    // q0 is the quotient or one short of it
    always_comb begin
        rem      = t4_reg - 17'(q0_reg) * 17'(DIV_K);
        lut_next = q0_reg + 13'(rem >= 17'(DIV_K));
    end

    always_comb begin
        blend_sum = 20'(lin5_reg) * 20'(FRAC_W'(STEP) - st5_item_reg.x)
                  + 20'(lut_reg) * 20'(st5_item_reg.x)
                  + 20'(STEP / 2);
        case (st5_item_reg.region)
            REGION_ZERO:  val = '0;
            REGION_LIN:   val = 14'(lin5_reg);
            REGION_BLEND: val = blend_sum[19:6];
            REGION_TAB:   val = 14'(lut_reg);
            default:      val = '0;
        endcase
        m_volt_next = (val > 14'(VOLT_MAX)) ? VOLT_W'(VOLT_MAX) : val[VOLT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= q_valid;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            st5_valid_reg <= st4_valid_reg;
            m_tvalid_reg  <= st5_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_item_reg <= q_item;
            p0_reg       <= p0_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            p3_reg       <= p3_next;
            lp_reg       <= lp_next;

            st2_item_reg <= st1_item_reg;
            a_reg        <= a_next;
            b_reg        <= b_next;
            lin2_reg     <= lin2_next;

            st3_item_reg <= st2_item_reg;
            t3_reg       <= t3_next;
            lin3_reg     <= lin2_reg;

            st4_item_reg <= st3_item_reg;
            q0_reg       <= q0_next;
            t4_reg       <= t3_reg;
            lin4_reg     <= lin3_reg;

            st5_item_reg <= st4_item_reg;
            lut_reg      <= lut_next;
            lin5_reg     <= lin4_reg;

            m_volt_reg   <= m_volt_next;
        end
    end

    // weighted sum stays positive and inside the 17-bit pre-shifted range
    assert property (@(posedge aclk) disable iff (!aresetn)
        st2_valid_reg |-> (s_sum[31:PRE_SHIFT+17] == '0))
        else $error("table sum out of range");

    // reciprocal estimate is never more than one short
    assert property (@(posedge aclk) disable iff (!aresetn)
        st4_valid_reg |-> (rem < 17'(2 * DIV_K)))
        else $error("reciprocal remainder out of range");

    // a stalled output freezes the whole pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(st1_valid_reg) && $stable(st5_valid_reg)))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

// ===== src/adc_lut_voltage_calibration_top.sv =====
// ADC code to millivolt calibration.
//
// Channels: s_ stream carries one 12-bit ADC code per beat, m_ stream
// returns one 12-bit voltage in millivolts per beat, in order. An APB
// port holds the 5-bit sign-magnitude fuse code (address 0, reset 0,
// i.e. 1100 mV reference); write it only while no beat is in flight.
// Throughput: one beat per cycle while m_tready stays high. An accepted
// code waits in a queue register, then passes the back pipeline stages
// up to and including the output register; the pipeline depth is set by
// the bilinear table path (product, two sums, weighted sum, reciprocal
// divide by 12800, correction, blend).
// Reset empties the queue and the pipeline; no beat is presented
// until a new code is accepted.
// Receiver stall: the whole back pipeline holds; the front keeps
// taking codes into the queue until it is full (QUEUE_DEPTH entries,
// at least 2 for full rate), then drops s_tready.
// Depends on alvc_pkg, alvc_front, alvc_queue and alvc_back.
`default_nettype none

module adc_lut_voltage_calibration_top import alvc_pkg::*; #(
    parameter int QUEUE_DEPTH = ALVC_QUEUE_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [APB_W-1:0]    pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic                     pready,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [TDATA_W-1:0]  s_tdata,   // [11:0] adc_code
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDATA_W-1:0]       m_tdata    // [11:0] voltage_mv
);

    function automatic logic [10:0] fuse_vref(input logic [FUSE_W-1:0] f);
        logic [6:0] step;
        begin
            step = 7'(f[3:0]) * 7'(VREF_STEP);
            return f[4] ? 11'(VREF_MID) - 11'(step) : 11'(VREF_MID) + 11'(step);
        end
    endfunction

    function automatic alvc_cfg_t fuse_derive(input logic [FUSE_W-1:0] f);
        logic [10:0] vref;
        logic [28:0] prod;
        logic [10:0] d1;
        logic [10:0] d2;
        alvc_cfg_t   c;
        begin
            vref  = fuse_vref(f);
            prod  = 29'(vref) * 29'(LIN_SCALE);
            d1    = vref - 11'(VREF_LO);
            d2    = 11'(VREF_HI) - vref;
            c.k   = prod[27:12];
            c.x2d = $signed(d2[XD_W:0]);
            c.x1d = $signed(d1[XD_W:0]);
            return c;
        end
    endfunction

    logic [FUSE_W-1:0]  fuse_reg, fuse_next;
    alvc_cfg_t          cfg_reg, cfg_next;
    logic               reg_hit, wr_en;

    alvc_item_t         front_item, q_item;
    logic               q_valid, q_pop;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_FUSE);
    assign wr_en   = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? APB_W'(fuse_reg) : '0;

    // derive the datapath constants as the fuse code is written
    always_comb begin
        fuse_next = fuse_reg;
        cfg_next  = cfg_reg;
        if (wr_en) begin
            fuse_next = pwdata[FUSE_W-1:0];
            cfg_next  = fuse_derive(pwdata[FUSE_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fuse_reg <= '0;
            cfg_reg  <= fuse_derive('0);
        end else begin
            fuse_reg <= fuse_next;
            cfg_reg  <= cfg_next;
        end
    end

    alvc_front u_front (
        .code (s_tdata[CODE_W-1:0]),
        .item (front_item)
    );

    alvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_item   (q_item)
    );

    alvc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
